@@ design/alb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alb_pkg
// Shared types and constants of the disc decipher core: disc size, fixed
// outer ring, fault codes, register indexes and the lookup result type.
// ----------------------------------------------------------------------------
package alb_pkg;

  localparam int DiscSize = 24;
  localparam int PosW     = 5;

  // fixed outer ring, position 0 first
  localparam logic [7:0] OuterRing [0:DiscSize-1] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h49,
    8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h54, 8'h56, 8'h58, 8'h5A, 8'h31, 8'h32, 8'h33, 8'h34
  };

  typedef enum logic [1:0] {
    FaultNone      = 2'd0,
    FaultDoubleInd = 2'd1,
    FaultUnknown   = 2'd2,
    FaultNoIndex   = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    RegDiscLow  = 2'd0,
    RegDiscMid  = 2'd1,
    RegDiscHigh = 2'd2,
    RegIndex    = 2'd3
  } cfg_reg_t;

  // result of a first-match search over a disc
  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] pos;
  } lookup_t;

endpackage

@@ design/alberti_disc_decipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alberti_disc_decipher_core
// Alberti disc decipher: one ciphertext byte in, one result word out, with
// displacement tracking from indicator characters and latched faults.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data                       | tuser
//  --------+-----------+------------------------------------+----------------
//  in_     | slave     | [7:0] cipher_byte                  | message_start
//  out_    | master    | [7:0] plain_byte, [9:8] fault_code | plain_valid
//  cfg_    | write     | cfg_index 0..3, cfg_data 64 bit    | -
//
//  one word per cycle sustained while out_tready holds high; a word passes
//  from the input register through the lookup and state update into the
//  output register, from where it leaves when out_tready is high
//  the state loop is the displacement/flag/fault update
//  reset (rst_n low, synchronous) empties both stages and sets displacement
//  to minus one, flag and fault to zero, and all disc registers to zero
//  a stall on out_tready holds the output word; the input register still
//  drains into the output register when that is free, so ready stays high
//  with one word waiting
//  configuration is taken every cycle (cfg_ready tied high)
// ----------------------------------------------------------------------------
module alberti_disc_decipher_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] cipher_byte
  input  logic        in_tuser,   // [0] message_start

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] plain_byte, [9:8] fault_code, zero above
  output logic        out_tuser,  // [0] plain_valid

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // modulo 24 of a value below 128 by three compare and subtract steps
  function automatic logic [alb_pkg::PosW-1:0] mod24(input logic [6:0] s);
    logic [6:0] t;
    t = s;
    if (t >= 7'd96) t = t - 7'd96;
    if (t >= 7'd48) t = t - 7'd48;
    if (t >= 7'd24) t = t - 7'd24;
    return t[alb_pkg::PosW-1:0];
  endfunction

  // configuration registers
  logic [63:0] disc_low_r, disc_mid_r, disc_high_r;
  logic [7:0]  index_char_r;
  logic [alb_pkg::DiscSize*8-1:0] disc;

  assign cfg_ready = 1'b1;
  assign disc      = {disc_high_r, disc_mid_r, disc_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_low_r   <= '0;
      disc_mid_r   <= '0;
      disc_high_r  <= '0;
      index_char_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (alb_pkg::cfg_reg_t'(cfg_index))
        alb_pkg::RegDiscLow:  disc_low_r   <= cfg_data;
        alb_pkg::RegDiscMid:  disc_mid_r   <= cfg_data;
        alb_pkg::RegDiscHigh: disc_high_r  <= cfg_data;
        alb_pkg::RegIndex:    index_char_r <= cfg_data[7:0];
        default:              ;
      endcase
    end
  end

  // stage handshakes
  logic s1_valid_r, out_valid_r;
  logic s1_start_r;
  logic [7:0] s1_byte_r;
  logic s2_free, s1_fire;

  assign s2_free   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // lookups: index character and the byte itself against the inner disc
  alb_pkg::lookup_t idx_lk, inner_lk, outer_lk;

  alb_disc_lookup u_idx_lookup (
    .disc   (disc),
    .key    (index_char_r),
    .result (idx_lk)
  );

  alb_disc_lookup u_byte_lookup (
    .disc   (disc),
    .key    (s1_byte_r),
    .result (inner_lk)
  );

  // outer ring is constant, so this is plain compare logic
  always_comb begin
    outer_lk = '0;
    for (int p = alb_pkg::DiscSize - 1; p >= 0; p--) begin
      if (alb_pkg::OuterRing[p] == s1_byte_r) begin
        outer_lk.hit = 1'b1;
        outer_lk.pos = alb_pkg::PosW'(p);
      end
    end
  end

  // message state
  logic [5:0]       disp_r, disp_nxt, disp_cur;
  logic             ind_r, ind_nxt, ind_cur;
  alb_pkg::fault_t  fault_r, fault_nxt, fault_cur;
  logic             plain_valid;
  logic [7:0]       plain_byte;
  logic [6:0]       sum;

  // message start clears the state before the byte is looked at
  assign disp_cur  = s1_start_r ? 6'h3F : disp_r;
  assign ind_cur   = s1_start_r ? 1'b0 : ind_r;
  assign fault_cur = s1_start_r ? alb_pkg::FaultNone : fault_r;

  // inner position + 48 + sign-extended displacement, always in 25..94
  assign sum = {2'b00, inner_lk.pos} + 7'd48 + {disp_cur[5], disp_cur};

  always_comb begin
    disp_nxt    = disp_cur;
    ind_nxt     = ind_cur;
    fault_nxt   = fault_cur;
    plain_valid = 1'b0;
    plain_byte  = 8'h00;
    if (fault_cur == alb_pkg::FaultNone) begin
      if (!idx_lk.hit) begin
        fault_nxt = alb_pkg::FaultNoIndex;
      end else if (inner_lk.hit) begin
        // inner disc wins over the outer ring
        plain_valid = 1'b1;
        plain_byte  = alb_pkg::OuterRing[mod24(sum)];
        ind_nxt     = 1'b0;
      end else if (outer_lk.hit) begin
        if (ind_cur) begin
          fault_nxt = alb_pkg::FaultDoubleInd;
        end else begin
          disp_nxt = {1'b0, outer_lk.pos} - {1'b0, idx_lk.pos};
          ind_nxt  = 1'b1;
        end
      end else begin
        fault_nxt = alb_pkg::FaultUnknown;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r  <= 6'h3F;
      ind_r   <= 1'b0;
      fault_r <= alb_pkg::FaultNone;
    end else if (s1_fire) begin
      disp_r  <= disp_nxt;
      ind_r   <= ind_nxt;
      fault_r <= fault_nxt;
    end
  end

  // output register
  logic [15:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {6'b000000, fault_nxt, plain_byte};
      out_user_r <= plain_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a latched fault survives any word without a message start
  a_fault_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_start_r && fault_r != alb_pkg::FaultNone) |=> fault_r == $past(fault_r))
    else $error("latched fault changed without message start");

  // a deciphered character never comes with a fault
  a_plain_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[9:8] == alb_pkg::FaultNone)
    else $error("plain character reported together with a fault");

  // no character means a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[7:0] == 8'h00)
    else $error("plain byte not zero on a word without a character");

  // state moves only when a word passes into the output register
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> ($stable(disp_r) && $stable(ind_r) && $stable(fault_r)))
    else $error("message state changed without a word");

endmodule

@@ design/alb_disc_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alb_disc_lookup
// Parallel compare of one byte against the 24 inner disc characters with a
// priority encoder; the lowest matching position wins.
// ----------------------------------------------------------------------------
module alb_disc_lookup (
  input  logic [alb_pkg::DiscSize*8-1:0] disc,
  input  logic [7:0]                     key,
  output alb_pkg::lookup_t               result
);

  logic [alb_pkg::DiscSize-1:0] match;

  always_comb begin
    for (int p = 0; p < alb_pkg::DiscSize; p++) begin
      match[p] = (disc[p*8 +: 8] == key);
    end
  end

  // scan from the top so the lowest match is the one that sticks
  always_comb begin
    result.hit = |match;
    result.pos = '0;
    for (int p = alb_pkg::DiscSize - 1; p >= 0; p--) begin
      if (match[p]) begin
        result.pos = alb_pkg::PosW'(p);
      end
    end
  end

endmodule
